// ----- rtl/tts_pkg.sv -----
// ----------------------------------------------------------------------------
// tts_pkg: shared types and constants for the text terminal scroll buffer
// Grid geometry, command codes, control characters and field widths.
// ----------------------------------------------------------------------------
package tts_pkg;

    // Grid geometry
    localparam int COLUMNS = 14;
    localparam int ROWS    = 6;

    // Field widths
    localparam int COL_W  = 4;
    localparam int ROW_W  = 3;
    localparam int CHAR_W = 8;
    localparam int KIND_W = 2;

    // Cursor limits
    localparam logic [COL_W-1:0] COL_END  = COL_W'(COLUMNS);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

    // Character codes
    localparam logic [CHAR_W-1:0] CODE_CR = 8'd13;
    localparam logic [CHAR_W-1:0] CODE_LF = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_BS = 8'd8;
    localparam logic [CHAR_W-1:0] BLANK   = 8'd32;

    // Command kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE = 2'd0,
        KIND_MOVE  = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_READ  = 2'd3
    } kind_t;

    // Command word held in the input stage
    typedef struct packed {
        kind_t              kind;
        logic [CHAR_W-1:0]  ch;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
    } cmd_word_t;

    // Result word held in the output stage
    typedef struct packed {
        logic [COL_W-1:0]   cursor_col;
        logic [ROW_W-1:0]   cursor_row;
        logic               scrolled;
        logic [CHAR_W-1:0]  cell_char;
    } rsp_word_t;

endpackage

// ----- rtl/tts_cmd_if.sv -----
// ----------------------------------------------------------------------------
// tts_cmd_if: command channel of the text terminal scroll buffer
// valid/ready handshake carrying one command word.
// ----------------------------------------------------------------------------
interface tts_cmd_if
    import tts_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] ch;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;

    modport source (output valid, output kind, output ch, output col, output row,
                    input ready);
    modport sink   (input valid, input kind, input ch, input col, input row,
                    output ready);
endinterface

// ----- rtl/tts_rsp_if.sv -----
// ----------------------------------------------------------------------------
// tts_rsp_if: result channel of the text terminal scroll buffer
// valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface tts_rsp_if
    import tts_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic              scrolled;
    logic [CHAR_W-1:0] cell_char;

    modport source (output valid, output cursor_col, output cursor_row,
                    output scrolled, output cell_char, input ready);
    modport sink   (input valid, input cursor_col, input cursor_row,
                    input scrolled, input cell_char, output ready);
endinterface

// ----- rtl/text_terminal_scroll_buffer.sv -----
// ----------------------------------------------------------------------------
// text_terminal_scroll_buffer: character grid with cursor and scroll
//
// Usage:
//   cmd  (sink)   takes one command word: write character, move cursor,
//                 clear screen or read cell. A word is taken when valid and
//                 ready are both high at a rising clk edge.
//   rsp  (source) gives exactly one result word per command: cursor column
//                 and row after the command, a scroll flag and, for a read,
//                 the cell contents (0 otherwise).
//   Path: an accepted word passes the input register, then the result
//   register, before rsp.valid rises. Throughput: one word per cycle while
//   rsp.ready stays high; the whole grid sits in flip-flops, so a scroll or
//   clear finishes in the compute step between the two registers.
//   Reset (rst_n low, asynchronous): every cell is space, the cursor is at
//   column 0 of the bottom row, both stages empty.
//   Stall: while rsp.ready is low the result word holds; the input stage
//   still takes one more word, then cmd.ready drops until rsp drains.
// ----------------------------------------------------------------------------
module text_terminal_scroll_buffer
    import tts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    tts_cmd_if.sink   cmd,
    tts_rsp_if.source rsp
);

    // Pipeline registers
    logic      s1_valid_reg;
    cmd_word_t s1_word_reg;
    logic      rsp_valid_reg;
    rsp_word_t rsp_word_reg;
    rsp_word_t rsp_word_next;

    // Terminal state
    logic [CHAR_W-1:0] cells_reg  [ROWS][COLUMNS];
    logic [CHAR_W-1:0] cells_next [ROWS][COLUMNS];
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;

    // Step controls
    logic              advance;
    logic              step_en;
    logic              do_scroll;
    logic              do_clear;
    logic              wr_en;
    logic [COL_W-1:0]  wr_col;
    logic [COL_W-1:0]  blank_from;
    logic [COL_W-1:0]  rd_col;
    logic [ROW_W-1:0]  rd_row;
    logic [COL_W-1:0]  cur_col_clamped;

    // Handshake: result stage moves when empty or drained
    assign advance   = !rsp_valid_reg || rsp.ready;
    assign step_en   = s1_valid_reg && advance;
    assign cmd.ready = !s1_valid_reg || advance;

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            s1_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            s1_word_reg.kind <= kind_t'(cmd.kind);
            s1_word_reg.ch   <= cmd.ch;
            s1_word_reg.col  <= cmd.col;
            s1_word_reg.row  <= cmd.row;
        end
    end

    // Clamped read address and cursor column
    assign rd_col = (s1_word_reg.col >= COL_END) ? COL_LAST : s1_word_reg.col;
    assign rd_row = (s1_word_reg.row > ROW_LAST) ? ROW_LAST : s1_word_reg.row;
    assign cur_col_clamped = (cur_col_reg >= COL_END) ? COL_LAST : cur_col_reg;

    // Command decode: cursor update and grid controls
    always_comb
    begin
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        do_scroll    = 1'b0;
        do_clear     = 1'b0;
        wr_en        = 1'b0;
        wr_col       = cur_col_reg;
        blank_from   = cur_col_clamped;
        unique case (s1_word_reg.kind)
            KIND_WRITE:
            begin
                priority if (s1_word_reg.ch == CODE_CR)
                begin
                    cur_col_next = '0;
                end
                else if (s1_word_reg.ch == CODE_LF)
                begin
                    do_scroll    = 1'b1;
                    cur_col_next = cur_col_clamped;
                end
                else if (s1_word_reg.ch == CODE_BS)
                begin
                    if (cur_col_reg >= COL_END)
                    begin
                        cur_col_next = COL_LAST;
                    end
                    else if (cur_col_reg != '0)
                    begin
                        cur_col_next = cur_col_reg - COL_W'(1);
                    end
                end
                else
                begin
                    // any other character; a pending wrap scrolls and blanks the whole row
                    if (cur_col_reg >= COL_END)
                    begin
                        do_scroll  = 1'b1;
                        blank_from = '0;
                        wr_col     = '0;
                    end
                    wr_en        = 1'b1;
                    cur_col_next = wr_col + COL_W'(1);
                end
            end
            KIND_MOVE:
            begin
                cur_col_next = rd_col;
                cur_row_next = rd_row;
            end
            KIND_CLEAR:
            begin
                do_clear     = 1'b1;
                cur_col_next = '0;
                cur_row_next = ROW_LAST;
            end
            KIND_READ:
            begin
                // no state change
            end
            default:
            begin
                // all codes covered
            end
        endcase
    end

    // Next grid: shift, blank tail of cursor row, store character, clear
    always_comb
    begin
        for (int r = 0; r < ROWS - 1; r++)
        begin
            for (int c = 0; c < COLUMNS; c++)
            begin
                cells_next[r][c] = do_scroll ? cells_reg[r+1][c] : cells_reg[r][c];
            end
        end
        for (int c = 0; c < COLUMNS; c++)
        begin
            cells_next[ROWS-1][c] = cells_reg[ROWS-1][c];
        end
        for (int r = 0; r < ROWS; r++)
        begin
            for (int c = 0; c < COLUMNS; c++)
            begin
                if (do_scroll && (ROW_W'(r) == cur_row_reg) && (COL_W'(c) >= blank_from))
                begin
                    cells_next[r][c] = BLANK;
                end
                if (wr_en && (ROW_W'(r) == cur_row_reg) && (COL_W'(c) == wr_col))
                begin
                    cells_next[r][c] = s1_word_reg.ch;
                end
                if (do_clear)
                begin
                    cells_next[r][c] = BLANK;
                end
            end
        end
    end

    // Terminal state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg <= '0;
            cur_row_reg <= ROW_LAST;
            for (int r = 0; r < ROWS; r++)
            begin
                for (int c = 0; c < COLUMNS; c++)
                begin
                    cells_reg[r][c] <= BLANK;
                end
            end
        end
        else if (step_en)
        begin
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
            cells_reg   <= cells_next;
        end
    end

    // Result word
    always_comb
    begin
        rsp_word_next.cursor_col = cur_col_next;
        rsp_word_next.cursor_row = cur_row_next;
        rsp_word_next.scrolled   = do_scroll;
        rsp_word_next.cell_char  = (s1_word_reg.kind == KIND_READ)
                                   ? cells_reg[rd_row][rd_col] : '0;
    end

    // Result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            rsp_word_reg <= rsp_word_next;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.cursor_col = rsp_word_reg.cursor_col;
    assign rsp.cursor_row = rsp_word_reg.cursor_row;
    assign rsp.scrolled   = rsp_word_reg.scrolled;
    assign rsp.cell_char  = rsp_word_reg.cell_char;

endmodule

// ----- rtl/tts_checker.sv -----
// ----------------------------------------------------------------------------
// tts_checker: port-level checks for the text terminal scroll buffer
// Watches the result channel; attached to the top level by bind.
// ----------------------------------------------------------------------------
module tts_checker
    import tts_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [COL_W-1:0]  cursor_col,
    input logic [ROW_W-1:0]  cursor_row,
    input logic              scrolled,
    input logic [CHAR_W-1:0] cell_char
);

    // A stalled result word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(cursor_col)
        && $stable(cursor_row) && $stable(scrolled) && $stable(cell_char))
        else $error("result word changed while stalled");

    // Cursor stays inside the grid (column may sit one past the end)
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (cursor_row <= ROW_LAST) && (cursor_col <= COL_END))
        else $error("cursor out of range");

    // A scroll always leaves the cursor on a real column
    a_scroll_col: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && scrolled |-> cursor_col < COL_END)
        else $error("wrap pending after scroll");

    // Only reads return a cell, and reads never scroll
    a_scroll_no_cell: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && scrolled |-> cell_char == '0)
        else $error("cell data on a scrolling word");

endmodule

bind text_terminal_scroll_buffer tts_checker u_tts_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .cursor_col (rsp.cursor_col),
    .cursor_row (rsp.cursor_row),
    .scrolled   (rsp.scrolled),
    .cell_char  (rsp.cell_char)
);

// ----- bench/text_terminal_scroll_buffer_test.sv -----
// ----------------------------------------------------------------------------
// text_terminal_scroll_buffer_test: self-checking bench for the scroll buffer
// Drives command words (write, move, clear, read) over the cmd channel with
// random gaps and drains result words with random stalls, including one long
// hold-off that backs the block up. A scoreboard tracks the character grid and
// cursor and compares every result word field by field.
// ----------------------------------------------------------------------------
module text_terminal_scroll_buffer_test;
    import tts_pkg::*;

    localparam int RANDOM_WORDS = 1400;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 80;
    localparam int HOLD_AT_WORD = 300;

    // ------------------------------------------------------------------------
    // Scoreboard: mirror of grid and cursor, queue of expected result words
    // ------------------------------------------------------------------------
    class screen_scoreboard;
        logic [CHAR_W-1:0] grid [ROWS*COLUMNS];
        logic [COL_W-1:0]  cur_col;
        logic [ROW_W-1:0]  cur_row;
        rsp_word_t         cursor_reports [$];
        int                errors;

        function void blank_screen();
            foreach (grid[i])
                grid[i] = BLANK;
            cur_col = '0;
            cur_row = ROW_LAST;
        endfunction

        function logic [COL_W-1:0] clamp_col(logic [COL_W-1:0] c);
            return (c >= COL_END) ? COL_LAST : c;
        endfunction

        function logic [ROW_W-1:0] clamp_row(logic [ROW_W-1:0] r);
            return (r > ROW_LAST) ? ROW_LAST : r;
        endfunction

        // rows move up by one, bottom row keeps its data, then the cursor
        // row is blanked from the (clamped) cursor column to the end
        function void scroll_up();
            for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
                grid[i] = grid[i + COLUMNS];
            cur_col = clamp_col(cur_col);
            for (int c = int'(cur_col); c < COLUMNS; c++)
                grid[int'(clamp_row(cur_row)) * COLUMNS + c] = BLANK;
        endfunction

        function void take_command(cmd_word_t w);
            rsp_word_t r;
            r.scrolled  = 1'b0;
            r.cell_char = '0;
            case (w.kind)
                KIND_WRITE:
                begin
                    if (w.ch == CODE_CR)
                        cur_col = '0;
                    else if (w.ch == CODE_LF)
                    begin
                        scroll_up();
                        r.scrolled = 1'b1;
                    end
                    else if (w.ch == CODE_BS)
                    begin
                        if (cur_col >= COL_END)
                            cur_col = COL_LAST;
                        else if (cur_col != '0)
                            cur_col = cur_col - 1'b1;
                    end
                    else
                    begin
                        // wrap pending: new line first
                        if (cur_col >= COL_END)
                        begin
                            cur_col = '0;
                            scroll_up();
                            r.scrolled = 1'b1;
                        end
                        grid[int'(clamp_row(cur_row)) * COLUMNS + int'(cur_col)] = w.ch;
                        cur_col = cur_col + 1'b1;
                    end
                end
                KIND_MOVE:
                begin
                    cur_col = clamp_col(w.col);
                    cur_row = clamp_row(w.row);
                end
                KIND_CLEAR:
                    blank_screen();
                default:
                    r.cell_char = grid[int'(clamp_row(w.row)) * COLUMNS
                                       + int'(clamp_col(w.col))];
            endcase
            r.cursor_col = cur_col;
            r.cursor_row = cur_row;
            cursor_reports.push_back(r);
        endfunction

        function void check_result(rsp_word_t got);
            rsp_word_t want;
            if (cursor_reports.size() == 0)
            begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            want = cursor_reports.pop_front();
            if (got.cursor_col !== want.cursor_col)
            begin
                $error("cursor_col: expected %0d, got %0d", want.cursor_col, got.cursor_col);
                errors++;
            end
            if (got.cursor_row !== want.cursor_row)
            begin
                $error("cursor_row: expected %0d, got %0d", want.cursor_row, got.cursor_row);
                errors++;
            end
            if (got.scrolled !== want.scrolled)
            begin
                $error("scrolled: expected %0d, got %0d", want.scrolled, got.scrolled);
                errors++;
            end
            if (got.cell_char !== want.cell_char)
            begin
                $error("cell_char: expected %0d, got %0d", want.cell_char, got.cell_char);
                errors++;
            end
        endfunction

        function int pending();
            return cursor_reports.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    tts_cmd_if cmd_ch ();
    tts_rsp_if rsp_ch ();

    screen_scoreboard sb = new;

    int  word_index;
    bit  calm;
    int  cycles;

    text_terminal_scroll_buffer u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // Clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic cmd_word_t make_cmd(kind_t k, logic [CHAR_W-1:0] c,
                                           logic [COL_W-1:0] x, logic [ROW_W-1:0] y);
        cmd_word_t w;
        w.kind = k;
        w.ch   = c;
        w.col  = x;
        w.row  = y;
        return w;
    endfunction

    // Offer one command word after a random gap, return once it is taken
    task automatic send_command(input cmd_word_t w);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.kind  <= w.kind;
        cmd_ch.ch    <= w.ch;
        cmd_ch.col   <= w.col;
        cmd_ch.row   <= w.row;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        sb.take_command(w);
        word_index++;
        calm = ((word_index / 120) % 4) == 3;
    endtask

    // Random command mix: mostly text with control codes, some moves/reads
    function automatic cmd_word_t random_cmd();
        int pick;
        int sel;
        logic [CHAR_W-1:0] c;
        pick = $urandom_range(0, 99);
        sel  = $urandom_range(0, 99);
        if (sel < 60)
            c = CHAR_W'($urandom_range(33, 126));
        else if (sel < 70)
            c = CODE_CR;
        else if (sel < 80)
            c = CODE_LF;
        else if (sel < 87)
            c = CODE_BS;
        else
            c = CHAR_W'($urandom_range(0, 255));
        if (pick < 68)
            return make_cmd(KIND_WRITE, c, COL_W'($urandom_range(0, 15)),
                            ROW_W'($urandom_range(0, 7)));
        else if (pick < 80)
            return make_cmd(KIND_MOVE, c, COL_W'($urandom_range(0, 15)),
                            ROW_W'($urandom_range(0, 7)));
        else if (pick < 82)
            return make_cmd(KIND_CLEAR, c, COL_W'($urandom_range(0, 15)),
                            ROW_W'($urandom_range(0, 7)));
        else
            return make_cmd(KIND_READ, c, COL_W'($urandom_range(0, 15)),
                            ROW_W'($urandom_range(0, 7)));
    endfunction

    // Result side: random stalls, one long hold-off, checks each word
    always @(posedge clk)
    begin : drain
        int        stall_left;
        int        hold_left;
        int        taken;
        bit        held;
        rsp_word_t got;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.cursor_col = rsp_ch.cursor_col;
                got.cursor_row = rsp_ch.cursor_row;
                got.scrolled   = rsp_ch.scrolled;
                got.cell_char  = rsp_ch.cell_char;
                sb.check_result(got);
                taken++;
                stall_left = calm ? 0 : $urandom_range(0, 6);
                if (taken == HOLD_AT_WORD && !held)
                begin
                    held      = 1'b1;
                    hold_left = HOLD_CYCLES;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
        else
            rsp_ch.ready <= 1'b0;
    end

    // Stimulus
    initial
    begin
        sb.blank_screen();
        cmd_ch.valid = 1'b0;
        cmd_ch.kind  = KIND_WRITE;
        cmd_ch.ch    = '0;
        cmd_ch.col   = '0;
        cmd_ch.row   = '0;
        rst_n        = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset contents, clamps, control codes, wrap handling
        send_command(make_cmd(KIND_READ,  8'h00, 4'd0,  3'd0));
        send_command(make_cmd(KIND_READ,  8'hFF, 4'd15, 3'd7));
        send_command(make_cmd(KIND_WRITE, 8'h41, 4'd0,  3'd0));
        send_command(make_cmd(KIND_WRITE, 8'hFF, 4'd15, 3'd7));
        send_command(make_cmd(KIND_WRITE, 8'h00, 4'd0,  3'd0));
        send_command(make_cmd(KIND_WRITE, CODE_BS, 4'd0, 3'd0));
        send_command(make_cmd(KIND_WRITE, CODE_CR, 4'd0, 3'd0));
        send_command(make_cmd(KIND_WRITE, CODE_BS, 4'd0, 3'd0));
        send_command(make_cmd(KIND_MOVE,  8'h00, 4'd15, 3'd7));
        send_command(make_cmd(KIND_WRITE, 8'h42, 4'd0,  3'd0));
        send_command(make_cmd(KIND_WRITE, CODE_BS, 4'd0, 3'd0));
        send_command(make_cmd(KIND_WRITE, 8'h43, 4'd0,  3'd0));
        send_command(make_cmd(KIND_WRITE, CODE_LF, 4'd0, 3'd0));
        send_command(make_cmd(KIND_WRITE, 8'h44, 4'd0,  3'd0));
        send_command(make_cmd(KIND_WRITE, 8'h45, 4'd0,  3'd0));
        send_command(make_cmd(KIND_WRITE, CODE_LF, 4'd0, 3'd0));
        send_command(make_cmd(KIND_MOVE,  8'h00, 4'd0,  3'd0));
        send_command(make_cmd(KIND_WRITE, 8'h46, 4'd0,  3'd0));
        send_command(make_cmd(KIND_READ,  8'h00, 4'd0,  3'd0));
        send_command(make_cmd(KIND_READ,  8'h00, 4'd13, 3'd4));
        send_command(make_cmd(KIND_CLEAR, 8'h00, 4'd0,  3'd0));
        send_command(make_cmd(KIND_READ,  8'h00, 4'd13, 3'd5));
        send_command(make_cmd(KIND_MOVE,  8'h00, 4'd7,  3'd3));
        send_command(make_cmd(KIND_WRITE, 8'h7E, 4'd0,  3'd0));
        send_command(make_cmd(KIND_READ,  8'h00, 4'd7,  3'd3));

        // Random traffic
        repeat (RANDOM_WORDS)
            send_command(random_cmd());
        cmd_ch.valid <= 1'b0;

        // Drain and settle
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
